>>> rtl/mfe_pkg.sv
// ----------------------------------------------------------------------------
// mfe_pkg
// Shared types and constants for the marked fragment extractor.
// ----------------------------------------------------------------------------
package mfe_pkg;

	// fragment length carried to the emitter; covers FRAGMENT_MAX up to 64
	localparam int LEN_W = 6;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [1:0] {
		PH_LEFT,
		PH_COLLECT,
		PH_DONE
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEFT_MARKER,
		REG_LEFT_LEN,
		REG_RIGHT_MARKER,
		REG_RIGHT_LEN
	} cfg_reg_t;

	// one completed fragment waiting to be emitted
	typedef struct packed {
		logic             bank;
		logic [LEN_W-1:0] len;
	} frag_desc_t;

	function automatic logic [7:0] marker_byte(input logic [63:0] m, input logic [2:0] i);
		return m[{i, 3'b000} +: 8];
	endfunction

endpackage

>>> rtl/mfe_queue.sv
// ----------------------------------------------------------------------------
// mfe_queue
// Two-entry queue of fragment descriptors between the front and the emitter.
// ----------------------------------------------------------------------------
module mfe_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mfe_pkg::frag_desc_t push_desc,
	input  logic                pop,
	output logic                full,
	output logic                head_valid,
	output mfe_pkg::frag_desc_t head
);
	import mfe_pkg::*;

	frag_desc_t  ent_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/mfe_front.sv
// ----------------------------------------------------------------------------
// mfe_front
// Holds the marker registers, runs the marker search over each accepted item,
// writes content bytes into the current store bank and hands completed
// fragments to the queue.
// ----------------------------------------------------------------------------
module mfe_front #(
	parameter int FRAGMENT_MAX = 32,
	parameter int MARKER_MAX   = 8
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          cfg_we,
	input  logic [mfe_pkg::CFG_IDX_W-1:0]                 cfg_index,
	input  logic [63:0]                                   cfg_data,
	input  logic                                          accept,
	input  logic [7:0]                                    data_byte,
	input  logic                                          restart,
	output logic                                          push,
	output mfe_pkg::frag_desc_t                           push_desc,
	output logic                                          store_we,
	output logic                                          store_bank,
	output logic [$clog2(FRAGMENT_MAX+MARKER_MAX-1)-1:0] store_addr,
	output logic [7:0]                                    store_data
);
	import mfe_pkg::*;

	localparam int STORE_DEPTH = FRAGMENT_MAX + MARKER_MAX - 1;
	localparam int AW          = $clog2(STORE_DEPTH);
	localparam int SW          = $clog2(STORE_DEPTH + 1);
	localparam int MW          = $clog2(MARKER_MAX + 1);

	logic [63:0]   left_marker_q;
	logic [3:0]    left_len_q;
	logic [63:0]   right_marker_q;
	logic [3:0]    right_len_q;
	phase_t        phase_q, phase_d;
	logic [MW-1:0] match_q, match_d;
	logic [SW-1:0] stored_q, stored_d;
	logic          wbank_q;

	phase_t        ph_c;
	logic [MW-1:0] mc_c, mc_inc, mc_keep, llen, rlen;
	logic [SW-1:0] sc_c, sc_inc, content;
	logic          hit_l, hit_r, done_l, done_r, ovf;

	function automatic logic [MW-1:0] eff_len(input logic [3:0] len);
		logic [MW-1:0] r;
		if (len == 4'd0) r = MW'(1);
		else if (len > 4'(MARKER_MAX)) r = MW'(MARKER_MAX);
		else r = MW'(len);
		return r;
	endfunction

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_marker_q  <= '0;
			left_len_q     <= 4'd1;
			right_marker_q <= '0;
			right_len_q    <= 4'd1;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LEFT_MARKER:  left_marker_q  <= cfg_data;
				REG_LEFT_LEN:     left_len_q     <= cfg_data[3:0];
				REG_RIGHT_MARKER: right_marker_q <= cfg_data;
				REG_RIGHT_LEN:    right_len_q    <= cfg_data[3:0];
			endcase
		end
	end

	// classify the incoming byte against the search state (restart applied first)
	always_comb begin
		ph_c    = restart ? PH_LEFT : phase_q;
		mc_c    = restart ? '0 : match_q;
		sc_c    = restart ? '0 : stored_q;
		llen    = eff_len(left_len_q);
		rlen    = eff_len(right_len_q);
		mc_inc  = mc_c + MW'(1);
		hit_l   = (mc_c < llen) && (data_byte == marker_byte(left_marker_q, 3'(mc_c)));
		hit_r   = (mc_c < rlen) && (data_byte == marker_byte(right_marker_q, 3'(mc_c)));
		done_l  = hit_l && (mc_inc >= llen);
		done_r  = hit_r && (mc_inc >= rlen);
		// bytes before the partial right marker already stored
		content = sc_c - SW'(mc_c);
		mc_keep = hit_r ? mc_inc : '0;
		sc_inc  = sc_c + SW'(1);
		ovf     = ((sc_inc - SW'(mc_keep)) >= SW'(FRAGMENT_MAX)) ||
		          (sc_inc >= SW'(STORE_DEPTH));
	end

	// next state
	always_comb begin
		phase_d  = phase_q;
		match_d  = match_q;
		stored_d = stored_q;
		if (accept) begin
			phase_d  = ph_c;
			match_d  = mc_c;
			stored_d = sc_c;
			unique case (ph_c)
				PH_LEFT: begin
					if (done_l) begin
						phase_d  = PH_COLLECT;
						match_d  = '0;
						stored_d = '0;
					end else if (hit_l) begin
						match_d = mc_inc;
					end else begin
						match_d = '0;
					end
				end
				PH_COLLECT: begin
					if (done_r) begin
						// empty content: search again from the left marker
						phase_d  = (content == '0) ? PH_LEFT : PH_DONE;
						match_d  = '0;
						stored_d = (content == '0) ? '0 : sc_c;
					end else if (ovf) begin
						phase_d  = PH_LEFT;
						match_d  = '0;
						stored_d = '0;
					end else begin
						match_d  = mc_keep;
						stored_d = sc_inc;
					end
				end
				default: ;
			endcase
		end
	end

	// outputs to the store and the queue
	always_comb begin
		push           = accept && (ph_c == PH_COLLECT) && done_r && (content != '0);
		push_desc.bank = wbank_q;
		push_desc.len  = LEN_W'(content);
		store_we       = accept && (ph_c == PH_COLLECT) && !done_r;
		store_bank     = wbank_q;
		store_addr     = AW'(sc_c);
		store_data     = data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LEFT;
			match_q  <= '0;
			stored_q <= '0;
			wbank_q  <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			match_q  <= match_d;
			stored_q <= stored_d;
			// the finished bank now belongs to the emitter
			if (push) wbank_q <= !wbank_q;
		end
	end

endmodule

>>> rtl/mfe_back.sv
// ----------------------------------------------------------------------------
// mfe_back
// Two-bank fragment store and the emitter that reads a finished fragment out,
// one byte per cycle unless the output stalls, into the output register.
// ----------------------------------------------------------------------------
module mfe_back #(
	parameter int FRAGMENT_MAX = 32,
	parameter int MARKER_MAX   = 8
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          store_we,
	input  logic                                          store_bank,
	input  logic [$clog2(FRAGMENT_MAX+MARKER_MAX-1)-1:0] store_addr,
	input  logic [7:0]                                    store_data,
	input  logic                                          head_valid,
	input  mfe_pkg::frag_desc_t                           head,
	output logic                                          pop,
	input  logic                                          out_ready,
	output logic                                          out_valid,
	output logic [7:0]                                    frag_byte,
	output logic                                          frag_last,
	output logic [4:0]                                    frag_length
);
	import mfe_pkg::*;

	localparam int STORE_DEPTH = FRAGMENT_MAX + MARKER_MAX - 1;
	localparam int AW          = $clog2(STORE_DEPTH);
	localparam int IW          = AW + 1;

	logic [7:0]    mem_q [2][STORE_DEPTH];
	logic [AW-1:0] idx_q;
	logic          valid_q;
	logic [7:0]    byte_q;
	logic          last_q;
	logic [4:0]    len_q;
	logic          issue, last;

	assign issue = head_valid && (!valid_q || out_ready);
	assign last  = (IW'(idx_q) + IW'(1)) == IW'(head.len);
	assign pop   = issue && last;

	always_ff @(posedge clk) begin
		if (store_we) mem_q[store_bank][store_addr] <= store_data;
		if (issue) begin
			byte_q <= mem_q[head.bank][idx_q];
			last_q <= last;
			len_q  <= head.len[4:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (issue) begin
				valid_q <= 1'b1;
				idx_q   <= last ? '0 : idx_q + AW'(1);
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = valid_q;
	assign frag_byte   = byte_q;
	assign frag_last   = last_q;
	assign frag_length = len_q;

endmodule

>>> rtl/marked_fragment_extractor_core.sv
// ----------------------------------------------------------------------------
// marked_fragment_extractor_core
// Finds a fragment between a left and a right marker in a byte stream and
// emits it as a run of items, the last one flagged.
//
// Input channel in_valid/in_ready carries one stream byte and a restart flag
// per item. Output channel out_valid/out_ready carries one fragment byte per
// item with frag_last and the fragment length. Markers and their lengths are
// written through cfg_we/cfg_index/cfg_data; the user must do so only while
// the block is idle, which the block itself does not enforce. Throughput: one
// input item per cycle while in_ready is high, one result per cycle while
// out_ready is high. The front writes into one of two store banks; in_ready
// drops only while two finished fragments are both waiting for the emitter,
// i.e. both banks are taken. A completed fragment's descriptor is registered
// in the queue, then the emitter reads its bytes into the output register.
// Reset clears the search state and sets the markers to zero, lengths to one.
// When the receiver stalls the output register holds its item, the emitter
// waits, and the input keeps flowing until both banks are taken.
// ----------------------------------------------------------------------------
module marked_fragment_extractor_core #(
	parameter int FRAGMENT_MAX = 32,
	parameter int MARKER_MAX   = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mfe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    data_byte,
	input  logic                          restart,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    frag_byte,
	output logic                          frag_last,
	output logic [4:0]                    frag_length
);
	import mfe_pkg::*;

	localparam int AW = $clog2(FRAGMENT_MAX + MARKER_MAX - 1);

	logic          accept;
	logic          push, pop, q_full, head_valid;
	frag_desc_t    push_desc, head;
	logic          store_we, store_bank;
	logic [AW-1:0] store_addr;
	logic [7:0]    store_data;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	mfe_front #(
		.FRAGMENT_MAX(FRAGMENT_MAX),
		.MARKER_MAX  (MARKER_MAX)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.data_byte (data_byte),
		.restart   (restart),
		.push      (push),
		.push_desc (push_desc),
		.store_we  (store_we),
		.store_bank(store_bank),
		.store_addr(store_addr),
		.store_data(store_data)
	);

	mfe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.full      (q_full),
		.head_valid(head_valid),
		.head      (head)
	);

	mfe_back #(
		.FRAGMENT_MAX(FRAGMENT_MAX),
		.MARKER_MAX  (MARKER_MAX)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.store_we   (store_we),
		.store_bank (store_bank),
		.store_addr (store_addr),
		.store_data (store_data),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.frag_byte  (frag_byte),
		.frag_last  (frag_last),
		.frag_length(frag_length)
	);

endmodule

>>> rtl/mfe_checker.sv
// ----------------------------------------------------------------------------
// mfe_checker
// Port-level checks on the extractor, bound to the top level.
// ----------------------------------------------------------------------------
module mfe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] frag_byte,
	input logic       frag_last,
	input logic [4:0] frag_length
);

	// a stalled item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frag_byte) &&
			$stable(frag_last) && $stable(frag_length))
		else $error("output item changed while stalled");

	// every item of one run carries the same length
	a_len_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !frag_last) ##1 out_valid |->
			frag_length == $past(frag_length))
		else $error("fragment length changed within a run");

	// a one-byte fragment is its own last item
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frag_length == 5'd1 |-> frag_last)
		else $error("one-byte fragment without last flag");

	// input only stalls while a fragment is being emitted
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with nothing at the output");

endmodule

bind marked_fragment_extractor_core mfe_checker u_mfe_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.frag_byte  (frag_byte),
	.frag_last  (frag_last),
	.frag_length(frag_length)
);
